// ----- sv/swcrm_pkg.sv -----
// ----------------------------------------------------------------------------
// swcrm_pkg
// Shared types and fixed field widths of the sliding window click rate meter.
// ----------------------------------------------------------------------------
package swcrm_pkg;

  localparam int NOW_W     = 32;
  localparam int ELAPSED_W = 24;
  localparam int WINDOW_W  = 24;
  localparam int SAMPLE_W  = 24;
  localparam int GMAX_W    = 6;
  localparam int ACCUM_W   = 25;
  localparam int TOTAL_W   = 32;
  localparam int RATE_W    = 7;
  localparam int AVG_W     = 15;
  localparam int FILL_W    = 7;
  localparam int FRAC_W    = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW = 2'd0,
    CFG_SAMPLE = 2'd1,
    CFG_GMAX   = 2'd2
  } cfg_idx_t;

  localparam logic [WINDOW_W-1:0] WINDOW_RST = 24'd1000000;
  localparam logic [SAMPLE_W-1:0] SAMPLE_RST = 24'd100000;
  localparam logic [GMAX_W-1:0]   GMAX_RST   = 6'd20;

  typedef struct packed {
    logic [NOW_W-1:0]   now;
    logic               click;
    logic               sampled;
    logic [TOTAL_W-1:0] total;
  } item_t;

  typedef struct packed {
    logic [RATE_W-1:0]  current_rate;
    logic [RATE_W-1:0]  peak_rate;
    logic [TOTAL_W-1:0] total_clicks;
    logic [AVG_W-1:0]   average_q8;
    logic [FILL_W-1:0]  history_fill;
    logic               sample_taken;
    logic               rate_high;
    logic               rate_active;
    logic               click_dropped;
  } result_t;

endpackage

// ----- sv/swcrm_front.sv -----
// ----------------------------------------------------------------------------
// swcrm_front
// Edge detect, click total and sample interval accumulation per tick.
// ----------------------------------------------------------------------------
module swcrm_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic [swcrm_pkg::NOW_W-1:0]     now_us,
  input  logic [swcrm_pkg::ELAPSED_W-1:0] elapsed_us,
  input  logic                           button_down,
  input  logic [swcrm_pkg::SAMPLE_W-1:0]  sample_interval,
  output swcrm_pkg::item_t               item
);

  logic                            prev_button_r, prev_button_nxt;
  logic [swcrm_pkg::TOTAL_W-1:0]   total_r, total_nxt;
  logic [swcrm_pkg::ACCUM_W-1:0]   accum_r, accum_nxt;
  logic [swcrm_pkg::ACCUM_W-1:0]   accum_sum;
  logic                            click;
  logic                            sampled;

  assign click     = button_down & ~prev_button_r;
  assign accum_sum = accum_r + swcrm_pkg::ACCUM_W'(elapsed_us);
  assign sampled   = accum_sum >= swcrm_pkg::ACCUM_W'(sample_interval);

  always_comb begin
    prev_button_nxt = prev_button_r;
    total_nxt       = total_r;
    accum_nxt       = accum_r;
    if (push) begin
      prev_button_nxt = button_down;
      total_nxt       = total_r + swcrm_pkg::TOTAL_W'(click);
      accum_nxt       = sampled ? '0 : accum_sum;
    end
  end

  always_comb begin
    item.now     = now_us;
    item.click   = click;
    item.sampled = sampled;
    item.total   = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_button_r <= 1'b0;
      total_r       <= '0;
      accum_r       <= '0;
    end else begin
      prev_button_r <= prev_button_nxt;
      total_r       <= total_nxt;
      accum_r       <= accum_nxt;
    end
  end

endmodule

// ----- sv/swcrm_queue.sv -----
// ----------------------------------------------------------------------------
// swcrm_queue
// Two-entry queue of classified ticks between front and back.
// ----------------------------------------------------------------------------
module swcrm_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  swcrm_pkg::item_t wr_item,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output swcrm_pkg::item_t rd_item
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  swcrm_pkg::item_t   slots [DEPTH];
  logic [PW-1:0]      wr_r, wr_nxt;
  logic [PW-1:0]      rd_r, rd_nxt;
  logic [PW:0]        cnt_r, cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign full    = cnt_r == (PW+1)'(DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rd_item = slots[rd_r];

  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (PW+1)'(do_push) - (PW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- sv/swcrm_div.sv -----
// ----------------------------------------------------------------------------
// swcrm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swcrm_div #(
  parameter int DVD_W = 21,
  parameter int DIV_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] dsr_r, dsr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DIV_W:0]   trial;
  logic             fits;

  assign trial    = {rem_r, quo_r[DVD_W-1]};
  assign fits     = trial >= {1'b0, dsr_r};
  assign busy     = busy_r;
  assign quotient = quo_r;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = CNT_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[DVD_W-2:0], fits};
      rem_nxt  = fits ? DIV_W'(trial - {1'b0, dsr_r}) : trial[DIV_W-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = cnt_r != CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ----- sv/swcrm_back.sv -----
// ----------------------------------------------------------------------------
// swcrm_back
// Stamp ring, window pruning, rate history, mean and result register.
// ----------------------------------------------------------------------------
module swcrm_back #(
  parameter int MAX_CLICKS    = 64,
  parameter int HISTORY_DEPTH = 80
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  swcrm_pkg::item_t              q_item,
  output logic                          q_pop,
  input  logic [swcrm_pkg::WINDOW_W-1:0] window,
  input  logic [swcrm_pkg::GMAX_W-1:0]   graph_max,
  output logic                          out_valid,
  input  logic                          out_pop,
  output swcrm_pkg::result_t            result
);

  localparam int CW    = $clog2(MAX_CLICKS);
  localparam int RW    = $clog2(MAX_CLICKS + 1);
  localparam int HW    = $clog2(HISTORY_DEPTH);
  localparam int HCW   = $clog2(HISTORY_DEPTH + 1);
  localparam int SUMW  = $clog2(HISTORY_DEPTH * MAX_CLICKS + 1);
  localparam int DVD_W = SUMW + swcrm_pkg::FRAC_W;
  localparam int CMPW  = (RW + 3 > swcrm_pkg::GMAX_W + 2) ? RW + 3 : swcrm_pkg::GMAX_W + 2;

  typedef enum logic [2:0] {
    S_IDLE, S_PRUNE_RD, S_PRUNE_CHK, S_HIST, S_HIST_RPL, S_DIV, S_DIV_WAIT, S_OUT
  } state_t;

  state_t                     state_r, state_nxt;
  swcrm_pkg::item_t           item_r, item_nxt;
  logic [CW-1:0]              head_r, head_nxt;
  logic [RW-1:0]              count_r, count_nxt;
  logic [RW-1:0]              peak_r, peak_nxt;
  logic [HW-1:0]              hhead_r, hhead_nxt;
  logic [HCW-1:0]             hcount_r, hcount_nxt;
  logic [SUMW-1:0]            hsum_r, hsum_nxt;
  logic                       dropped_r, dropped_nxt;
  logic                       out_valid_r, out_valid_nxt;
  swcrm_pkg::result_t         res_r, res_nxt;

  logic [swcrm_pkg::NOW_W-1:0] stamps [MAX_CLICKS];
  logic [swcrm_pkg::NOW_W-1:0] stamp_rd_r;
  logic                        stamp_we, stamp_re;
  logic [CW-1:0]               stamp_waddr;
  logic [RW-1:0]               hist_mem [HISTORY_DEPTH];
  logic [RW-1:0]               hist_rd_r;
  logic                        hist_we, hist_re;
  logic [HW-1:0]               hist_waddr;

  logic [CW:0]                 stamp_slot;
  logic [HW:0]                 hist_slot;
  logic [CW-1:0]               head_inc;
  logic [HW-1:0]               hhead_inc;
  logic [swcrm_pkg::NOW_W-1:0] age;
  logic [CMPW-1:0]             rate5;
  logic [CMPW-1:0]             gmax4;

  logic                        div_start;
  logic                        div_busy;
  logic [DVD_W-1:0]            div_q;

  swcrm_div #(
    .DVD_W (DVD_W),
    .DIV_W (HCW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({hsum_r, swcrm_pkg::FRAC_W'(0)}),
    .divisor  (hcount_r),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_comb begin
    stamp_slot = (CW+1)'(head_r) + (CW+1)'(count_r);
    if (stamp_slot >= (CW+1)'(MAX_CLICKS)) begin
      stamp_slot = stamp_slot - (CW+1)'(MAX_CLICKS);
    end
    hist_slot = (HW+1)'(hhead_r) + (HW+1)'(hcount_r);
    if (hist_slot >= (HW+1)'(HISTORY_DEPTH)) begin
      hist_slot = hist_slot - (HW+1)'(HISTORY_DEPTH);
    end
    head_inc  = (head_r == CW'(MAX_CLICKS - 1)) ? '0 : head_r + 1'b1;
    hhead_inc = (hhead_r == HW'(HISTORY_DEPTH - 1)) ? '0 : hhead_r + 1'b1;
  end

  assign age   = item_r.now - stamp_rd_r;
  assign rate5 = (CMPW'(count_r) << 2) + CMPW'(count_r);
  assign gmax4 = CMPW'(graph_max) << 2;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    peak_nxt      = peak_r;
    hhead_nxt     = hhead_r;
    hcount_nxt    = hcount_r;
    hsum_nxt      = hsum_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    q_pop         = 1'b0;
    stamp_we      = 1'b0;
    stamp_re      = 1'b0;
    stamp_waddr   = stamp_slot[CW-1:0];
    hist_we       = 1'b0;
    hist_re       = 1'b0;
    hist_waddr    = hist_slot[HW-1:0];
    div_start     = 1'b0;

    if (out_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          item_nxt    = q_item;
          dropped_nxt = 1'b0;
          if (q_item.click) begin
            if (count_r < RW'(MAX_CLICKS)) begin
              stamp_we  = 1'b1;
              count_nxt = count_r + 1'b1;
            end else begin
              dropped_nxt = 1'b1;
            end
          end
          state_nxt = S_PRUNE_RD;
        end
      end
      S_PRUNE_RD: begin
        if (count_r == '0) begin
          state_nxt = S_HIST;
        end else begin
          stamp_re  = 1'b1;
          state_nxt = S_PRUNE_CHK;
        end
      end
      S_PRUNE_CHK: begin
        if (age > swcrm_pkg::NOW_W'(window)) begin
          head_nxt  = head_inc;
          count_nxt = count_r - 1'b1;
          state_nxt = S_PRUNE_RD;
        end else begin
          state_nxt = S_HIST;
        end
      end
      S_HIST: begin
        if (count_r > peak_r) begin
          peak_nxt = count_r;
        end
        state_nxt = S_DIV;
        if (item_r.sampled) begin
          if (hcount_r == HCW'(HISTORY_DEPTH)) begin
            hist_re   = 1'b1;
            state_nxt = S_HIST_RPL;
          end else begin
            hist_we    = 1'b1;
            hcount_nxt = hcount_r + 1'b1;
            hsum_nxt   = hsum_r + SUMW'(count_r);
          end
        end
      end
      S_HIST_RPL: begin
        hist_we    = 1'b1;
        hist_waddr = hhead_r;
        hsum_nxt   = hsum_r - SUMW'(hist_rd_r) + SUMW'(count_r);
        hhead_nxt  = hhead_inc;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        if (hcount_r != '0) begin
          div_start = 1'b1;
          state_nxt = S_DIV_WAIT;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIV_WAIT: begin
        if (!div_busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_pop) begin
          res_nxt.current_rate  = swcrm_pkg::RATE_W'(count_r);
          res_nxt.peak_rate     = swcrm_pkg::RATE_W'(peak_r);
          res_nxt.total_clicks  = item_r.total;
          res_nxt.average_q8    = (hcount_r == '0) ? '0 : swcrm_pkg::AVG_W'(div_q);
          res_nxt.history_fill  = swcrm_pkg::FILL_W'(hcount_r);
          res_nxt.sample_taken  = item_r.sampled;
          res_nxt.rate_high     = rate5 > gmax4;
          res_nxt.rate_active   = count_r != '0;
          res_nxt.click_dropped = dropped_r;
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (stamp_we) begin
      stamps[stamp_waddr] <= q_item.now;
    end
    if (stamp_re) begin
      stamp_rd_r <= stamps[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= count_r;
    end
    if (hist_re) begin
      hist_rd_r <= hist_mem[hhead_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      peak_r      <= '0;
      hhead_r     <= '0;
      hcount_r    <= '0;
      hsum_r      <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      peak_r      <= peak_nxt;
      hhead_r     <= hhead_nxt;
      hcount_r    <= hcount_nxt;
      hsum_r      <= hsum_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign result    = res_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= RW'(MAX_CLICKS))
    else $error("stamp count above ring depth");

  a_hcount_max: assert property (@(posedge clk) disable iff (!rst_n)
    hcount_r <= HCW'(HISTORY_DEPTH))
    else $error("history count above depth");

  a_out_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result loaded outside output state");

  a_chk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PRUNE_CHK) |-> (count_r != '0))
    else $error("prune check with empty ring");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_PRUNE_RD))
    else $error("tick taken without entering prune");

endmodule

// ----- sv/sliding_window_click_rate_meter_unit.sv -----
// ----------------------------------------------------------------------------
// sliding_window_click_rate_meter_unit
// Counts button clicks in a sliding time window, keeps the peak and a
// sampled rate history with its Q7.8 mean.
//
//   channel | ports                              | transfer when
//   --------+------------------------------------+----------------------
//   in      | in_push, in_full, in_now_us, ...   | in_push & !in_full
//   out     | out_pop, out_empty, out_*          | out_pop & !out_empty
//   cfg     | cfg_we, cfg_index, cfg_wdata       | cfg_we
//
// Each tick retires the stamps that have left the window one at a time
// through the stamp ring read port, then runs the serial mean divider
// (quotient width 21 at default sizes; skipped while the history is
// empty). A two-entry queue takes ticks while the
// back end works, and a result register holds the last result until popped.
// Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sliding_window_click_rate_meter_unit #(
  parameter int MAX_CLICKS    = 64,
  parameter int HISTORY_DEPTH = 80
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [swcrm_pkg::NOW_W-1:0]        in_now_us,
  input  logic [swcrm_pkg::ELAPSED_W-1:0]    in_elapsed_us,
  input  logic                              in_button_down,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [swcrm_pkg::RATE_W-1:0]       out_current_rate,
  output logic [swcrm_pkg::RATE_W-1:0]       out_peak_rate,
  output logic [swcrm_pkg::TOTAL_W-1:0]      out_total_clicks,
  output logic [swcrm_pkg::AVG_W-1:0]        out_average_q8,
  output logic [swcrm_pkg::FILL_W-1:0]       out_history_fill,
  output logic                              out_sample_taken,
  output logic                              out_rate_high,
  output logic                              out_rate_active,
  output logic                              out_click_dropped,
  input  logic                              cfg_we,
  input  logic [swcrm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [swcrm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [swcrm_pkg::WINDOW_W-1:0] window_r, window_nxt;
  logic [swcrm_pkg::SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [swcrm_pkg::GMAX_W-1:0]   gmax_r, gmax_nxt;

  logic               q_full;
  logic               q_empty;
  logic               q_pop;
  logic               accept;
  swcrm_pkg::item_t   front_item;
  swcrm_pkg::item_t   q_item;
  logic               out_valid;
  swcrm_pkg::result_t result;

  always_comb begin
    window_nxt = window_r;
    sample_nxt = sample_r;
    gmax_nxt   = gmax_r;
    if (cfg_we) begin
      unique case (cfg_index)
        swcrm_pkg::CFG_WINDOW: window_nxt = cfg_wdata[swcrm_pkg::WINDOW_W-1:0];
        swcrm_pkg::CFG_SAMPLE: sample_nxt = cfg_wdata[swcrm_pkg::SAMPLE_W-1:0];
        swcrm_pkg::CFG_GMAX:   gmax_nxt   = cfg_wdata[swcrm_pkg::GMAX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= swcrm_pkg::WINDOW_RST;
      sample_r <= swcrm_pkg::SAMPLE_RST;
      gmax_r   <= swcrm_pkg::GMAX_RST;
    end else begin
      window_r <= window_nxt;
      sample_r <= sample_nxt;
      gmax_r   <= gmax_nxt;
    end
  end

  assign in_full = q_full;
  assign accept  = in_push & ~q_full;

  swcrm_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (accept),
    .now_us          (in_now_us),
    .elapsed_us      (in_elapsed_us),
    .button_down     (in_button_down),
    .sample_interval (sample_r),
    .item            (front_item)
  );

  swcrm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (accept),
    .wr_item (front_item),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_item (q_item)
  );

  swcrm_back #(
    .MAX_CLICKS    (MAX_CLICKS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .window    (window_r),
    .graph_max (gmax_r),
    .out_valid (out_valid),
    .out_pop   (out_pop),
    .result    (result)
  );

  assign out_empty         = ~out_valid;
  assign out_current_rate  = result.current_rate;
  assign out_peak_rate     = result.peak_rate;
  assign out_total_clicks  = result.total_clicks;
  assign out_average_q8    = result.average_q8;
  assign out_history_fill  = result.history_fill;
  assign out_sample_taken  = result.sample_taken;
  assign out_rate_high     = result.rate_high;
  assign out_rate_active   = result.rate_active;
  assign out_click_dropped = result.click_dropped;

endmodule
